[hw/rtl/kidi_pkg.sv]
package kidi_pkg;

  // field widths
  localparam int unsigned CRD_W  = 24;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 6;

  // squared distance: two squares of 25-bit differences
  localparam int unsigned D2_W = 2 * (CRD_W + 1);

  // weight = floor(2^52 / d2)
  localparam int unsigned WFRAC = 52;
  localparam int unsigned W_W   = WFRAC + 1;

  // accumulator and divider
  localparam int unsigned ACC_W  = 128;
  localparam int unsigned QUO_W  = 64;
  localparam int unsigned DCNT_W = 8;

  localparam logic [CFG_W-1:0] DEFAULT_NEIGHBOURS = 6'd12;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MASKED = 2'd2;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [VAL_W-1:0] val_t;

endpackage

[hw/rtl/kidi_in_if.sv]
interface kidi_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  kidi_pkg::crd_t                        north;
  kidi_pkg::crd_t                        east;
  kidi_pkg::val_t                        value_z;
  logic                                  masked_out;

  modport source (output valid, cmd, north, east, value_z, masked_out, input ready);
  modport sink   (input valid, cmd, north, east, value_z, masked_out, output ready);
endinterface

[hw/rtl/kidi_out_if.sv]
interface kidi_out_if;
  logic                              valid;
  logic                              ready;
  kidi_pkg::val_t                    interpolated;
  logic [kidi_pkg::STAT_W-1:0]       status;
  logic                              points_dropped;

  modport source (output valid, interpolated, status, points_dropped, input ready);
  modport sink   (input valid, interpolated, status, points_dropped, output ready);
endinterface

[hw/rtl/kidi_ram.sv]
module kidi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/knn_inverse_distance_interpolator.sv]
// channel  dir  handshake     beat contents
// in_chan  in   valid/ready   cmd, north, east, value_z, masked_out
// out_chan out  valid/ready   interpolated, status, points_dropped
// cfg_     in   cfg_we        cfg_wdata = neighbour_count
//
// a query scans the point store (one point store read per cycle, paused while
// a replacement of the farthest neighbour rescans the list), then runs the
// serial weight divider and multiply for each neighbour, then the final
// serial divide
// reset (rst_n low, synchronous) empties the store and clears the drop flag
// in_chan.ready is high only between queries; a finished result waits in the
// output register while loads go on
module knn_inverse_distance_interpolator #(
  parameter int unsigned MAX_POINTS     = 4096,
  parameter int unsigned MAX_NEIGHBOURS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  kidi_in_if.sink                     in_chan,
  kidi_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [kidi_pkg::CFG_W-1:0]  cfg_wdata
);
  import kidi_pkg::*;

  localparam int unsigned PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned LAW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int unsigned KW   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned S2W  = WFRAC + KW;
  localparam int unsigned DVW  = S2W + 1;
  localparam int unsigned SW   = 2 * CRD_W + VAL_W;
  localparam int unsigned LW   = D2_W + VAL_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_RESCAN = 4'd2;
  localparam logic [3:0] S_SUM_RD = 4'd3;
  localparam logic [3:0] S_SUM_LD = 4'd4;
  localparam logic [3:0] S_WDIV   = 4'd5;
  localparam logic [3:0] S_MAC1   = 4'd6;
  localparam logic [3:0] S_MAC2   = 4'd7;
  localparam logic [3:0] S_MAC3   = 4'd8;
  localparam logic [3:0] S_FIN1   = 4'd9;
  localparam logic [3:0] S_FIN2   = 4'd10;
  localparam logic [3:0] S_FDIV   = 4'd11;
  localparam logic [3:0] S_FRES   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   ncfg_r;
  logic [CW-1:0]      count_r;
  logic               ovf_r;
  crd_t               qn_r, qe_r;
  logic [KW-1:0]      k_r;

  // point store and nearest list
  logic               st_we;
  logic [PAW-1:0]     st_raddr;
  logic [SW-1:0]      st_rdata;
  logic               nl_we;
  logic [LAW-1:0]     nl_waddr, nl_raddr;
  logic [LW-1:0]      nl_wdata, nl_rdata;

  // scan pipeline
  logic [CW-1:0]      rd_i_r;
  logic               p1v_r, p2v_r, p3v_r;
  logic [CW-1:0]      tag1_r, tag2_r, tag3_r;
  logic [D2_W-2:0]    sqn_r, sqe_r;
  val_t               z2_r, z3_r;
  logic [D2_W-1:0]    d2_r;
  logic [D2_W-1:0]    maxd_r;
  logic [LAW-1:0]     m_r;

  // rescan of the list
  logic [KW-1:0]      rs_i_r, rs_tag_r;
  logic               rsv_r;

  // sum, multiply and divide
  logic [KW-1:0]      j_r;
  logic [VAL_W-1:0]   zmag_r;
  logic               zneg_r;
  logic [W_W-1:0]     w_r;
  logic [QUO_W-1:0]   prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [S2W-1:0]     s2_r;
  logic               neg_r;
  logic [ACC_W-1:0]   dnum_r;
  logic [DVW-1:0]     dden_r, drem_r;
  logic [QUO_W-1:0]   dq_r;
  logic [DCNT_W-1:0]  dcnt_r;

  val_t               res_r;
  logic [STAT_W-1:0]  stat_r;

  // derived combinational values
  logic               in_acc, query_go;
  logic [6:0]         k_lim;
  logic [CMPW-1:0]    k_full;
  logic signed [CRD_W:0]     dn, de;
  logic signed [2*CRD_W+1:0] pn, pe;
  logic               p3_fill, p3_repl, scan_done;
  logic [D2_W-1:0]    ld_d;
  val_t               ld_z;
  logic [DVW:0]       rem2;
  logic               ge;
  logic [ACC_W-1:0]   acc_add1, acc_add2;
  logic [QUO_W-1:0]   qsat;

  kidi_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (PAW'(count_r)),
    .wdata ({in_chan.north, in_chan.east, in_chan.value_z}),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  kidi_ram #(.WIDTH(LW), .DEPTH(MAX_NEIGHBOURS)) u_near (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign query_go = in_acc && (in_chan.cmd == CMD_QUERY);
  assign st_we    = in_acc && (in_chan.cmd == CMD_LOAD) && (CW'(MAX_POINTS) != count_r);

  // effective neighbour count
  always_comb begin
    if (ncfg_r == '0) begin
      k_lim = 7'd1;
    end else if ({1'b0, ncfg_r} > 7'(MAX_NEIGHBOURS)) begin
      k_lim = 7'(MAX_NEIGHBOURS);
    end else begin
      k_lim = {1'b0, ncfg_r};
    end
    k_full = (CMPW'(k_lim) < CMPW'(count_r)) ? CMPW'(k_lim) : CMPW'(count_r);
  end

  // distance stage arithmetic
  assign dn = {st_rdata[SW-1], st_rdata[SW-1 -: CRD_W]} - {qn_r[CRD_W-1], qn_r};
  assign de = {st_rdata[SW-CRD_W-1], st_rdata[SW-CRD_W-1 -: CRD_W]} - {qe_r[CRD_W-1], qe_r};
  assign pn = dn * dn;
  assign pe = de * de;

  assign p3_fill   = p3v_r && (CMPW'(tag3_r) < CMPW'(k_r));
  assign p3_repl   = p3v_r && !p3_fill && (d2_r < maxd_r);
  assign scan_done = (rd_i_r == count_r) && !p1v_r && !p2v_r && !p3v_r;

  assign st_raddr = PAW'(rd_i_r);

  // list port selection
  assign nl_we    = (state_r == S_SCAN) && (p3_fill || p3_repl);
  assign nl_waddr = p3_fill ? LAW'(tag3_r) : m_r;
  assign nl_wdata = {d2_r, z3_r};
  assign nl_raddr = (state_r == S_RESCAN) ? LAW'(rs_i_r) : LAW'(j_r);
  assign ld_d     = nl_rdata[LW-1 -: D2_W];
  assign ld_z     = nl_rdata[VAL_W-1:0];

  // one restoring divider step
  assign rem2 = {drem_r, dnum_r[ACC_W-1]};
  assign ge   = (rem2 >= {1'b0, dden_r});

  // signed accumulate of the partial products
  assign acc_add1 = zneg_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  assign acc_add2 = zneg_r ? acc_r - ACC_W'({prod_r, 32'd0}) : acc_r + ACC_W'({prod_r, 32'd0});

  // final saturation
  always_comb begin
    if (neg_r) begin
      qsat = (dq_r > QUO_W'(64'h8000_0000)) ? QUO_W'(64'h8000_0000) : dq_r;
      qsat = QUO_W'(0) - qsat;
    end else begin
      qsat = (dq_r > QUO_W'(64'h7FFF_FFFF)) ? QUO_W'(64'h7FFF_FFFF) : dq_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (query_go) begin
          if (count_r == '0 || in_chan.masked_out) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (p3_repl) begin
          state_nxt = S_RESCAN;
        end else if (scan_done) begin
          state_nxt = S_SUM_RD;
        end
      end
      S_RESCAN: begin
        if (rs_i_r == k_r && !rsv_r) begin
          state_nxt = S_SCAN;
        end
      end
      S_SUM_RD: state_nxt = S_SUM_LD;
      S_SUM_LD: state_nxt = (ld_d == '0) ? S_OUT : S_WDIV;
      S_WDIV:   state_nxt = (dcnt_r == DCNT_W'(1)) ? S_MAC1 : S_WDIV;
      S_MAC1:   state_nxt = S_MAC2;
      S_MAC2:   state_nxt = S_MAC3;
      S_MAC3:   state_nxt = (j_r + KW'(1) == k_r) ? S_FIN1 : S_SUM_RD;
      S_FIN1:   state_nxt = S_FIN2;
      S_FIN2:   state_nxt = S_FDIV;
      S_FDIV:   state_nxt = (dcnt_r == DCNT_W'(1)) ? S_FRES : S_FDIV;
      S_FRES:   state_nxt = S_OUT;
      S_OUT: begin
        if (!out_chan.valid || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ncfg_r         <= DEFAULT_NEIGHBOURS;
      count_r        <= '0;
      ovf_r          <= 1'b0;
      out_chan.valid <= 1'b0;
      p1v_r          <= 1'b0;
      p2v_r          <= 1'b0;
      p3v_r          <= 1'b0;
      rsv_r          <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        ncfg_r <= cfg_wdata;
      end
      // load beats
      if (in_acc && in_chan.cmd == CMD_LOAD) begin
        if (st_we) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // scan pipeline valids, flushed on a replacement
      if (state_r == S_SCAN && !p3_repl) begin
        p1v_r <= (rd_i_r != count_r);
        p2v_r <= p1v_r;
        p3v_r <= p2v_r;
      end else begin
        p1v_r <= 1'b0;
        p2v_r <= 1'b0;
        p3v_r <= 1'b0;
      end
      rsv_r <= (state_r == S_RESCAN) && (rs_i_r != k_r);
      // result register
      if (state_r == S_OUT && state_nxt == S_IDLE) begin
        out_chan.valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_chan.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // query start
    if (query_go) begin
      qn_r   <= in_chan.north;
      qe_r   <= in_chan.east;
      k_r    <= KW'(k_full);
      rd_i_r <= '0;
      res_r  <= '0;
      stat_r <= (count_r == '0) ? STAT_EMPTY :
                (in_chan.masked_out ? STAT_MASKED : STAT_OK);
    end

    // distance pipeline
    if (state_r == S_SCAN) begin
      if (p3_repl) begin
        rd_i_r <= tag3_r + CW'(1);
        rs_i_r <= '0;
      end else if (rd_i_r != count_r) begin
        rd_i_r <= rd_i_r + CW'(1);
      end
    end
    tag1_r <= rd_i_r;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    sqn_r  <= pn[D2_W-2:0];
    sqe_r  <= pe[D2_W-2:0];
    z2_r   <= st_rdata[VAL_W-1:0];
    d2_r   <= {1'b0, sqn_r} + {1'b0, sqe_r};
    z3_r   <= z2_r;

    // running maximum while the list fills
    if (state_r == S_SCAN && p3_fill) begin
      if (tag3_r == '0 || maxd_r < d2_r) begin
        maxd_r <= d2_r;
        m_r    <= LAW'(tag3_r);
      end
    end

    // first-found maximum search over the list
    if (state_r == S_RESCAN) begin
      if (rs_i_r != k_r) begin
        rs_i_r <= rs_i_r + KW'(1);
      end
      rs_tag_r <= rs_i_r;
      if (rsv_r && (rs_tag_r == '0 || maxd_r < ld_d)) begin
        maxd_r <= ld_d;
        m_r    <= LAW'(rs_tag_r);
      end
    end

    // sum setup
    if (state_r == S_SCAN && scan_done) begin
      j_r   <= '0;
      acc_r <= '0;
      s2_r  <= '0;
    end

    // divider
    if (state_r == S_WDIV || state_r == S_FDIV) begin
      drem_r <= ge ? DVW'(rem2 - {1'b0, dden_r}) : DVW'(rem2);
      dq_r   <= {dq_r[QUO_W-2:0], ge};
      dnum_r <= {dnum_r[ACC_W-2:0], 1'b0};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end

    case (state_r)
      S_SUM_LD: begin
        if (ld_d == '0) begin
          res_r <= ld_z;
        end else begin
          zneg_r <= ld_z[VAL_W-1];
          zmag_r <= ld_z[VAL_W-1] ? VAL_W'(-ld_z) : ld_z;
          dnum_r <= {1'b1, {(ACC_W-1){1'b0}}};
          dden_r <= DVW'(ld_d);
          drem_r <= '0;
          dq_r   <= '0;
          dcnt_r <= DCNT_W'(W_W);
        end
      end
      S_MAC1: begin
        w_r    <= dq_r[W_W-1:0];
        prod_r <= zmag_r * dq_r[31:0];
        s2_r   <= s2_r + S2W'(dq_r[W_W-1:0]);
      end
      S_MAC2: begin
        acc_r  <= acc_add1;
        prod_r <= QUO_W'(zmag_r * w_r[W_W-1:32]);
      end
      S_MAC3: begin
        acc_r <= acc_add2;
        j_r   <= j_r + KW'(1);
      end
      S_FIN1: begin
        acc_r <= {acc_r[ACC_W-2:0], 1'b0} + ACC_W'(s2_r);
      end
      S_FIN2: begin
        neg_r  <= acc_r[ACC_W-1];
        dnum_r <= acc_r[ACC_W-1] ? ACC_W'(0) - acc_r : acc_r;
        dden_r <= {s2_r, 1'b0};
        drem_r <= '0;
        dq_r   <= '0;
        dcnt_r <= DCNT_W'(ACC_W);
      end
      S_FRES: begin
        res_r <= qsat[VAL_W-1:0];
      end
      default: begin
      end
    endcase

    // result beat
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_chan.interpolated   <= res_r;
      out_chan.status         <= stat_r;
      out_chan.points_dropped <= ovf_r;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("drop flag cleared without reset");

  a_tag_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && p3v_r) |-> (tag3_r < count_r))
    else $error("scan pipeline holds an unwritten point");

  a_k_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_RESCAN) |-> (k_r != '0 && CMPW'(k_r) <= CMPW'(count_r)))
    else $error("neighbour count out of range during scan");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WDIV || state_r == S_FDIV) |-> (dcnt_r != '0))
    else $error("divider running with no steps left");

endmodule
